// File: sv/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Widths fixed by the register map and the stream fields
  localparam int BYTE_W          = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int LEN_W           = 4;
  localparam int MAX_LEN_CAP     = CFG_DATA_W / BYTE_W;
  localparam int MAX_LEN_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int SLOT_W          = $clog2(MAX_LEN_CAP);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_BYTES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN      = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // One output run: up to MAX_LEN_CAP bytes, emitted from slot 0 upward.
  // len == 0 with eos set is the empty end result.
  typedef struct packed {
    byte_t [MAX_LEN_CAP-1:0] bytes;
    logic [LEN_W-1:0]        len;
    logic                    eos;
  } job_t;

endpackage

`default_nettype wire

// File: sv/sfr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input text channel
interface sfr_in_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              end_of_stream;

  modport source (output valid, output data_byte, output has_byte, output end_of_stream,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input end_of_stream,
                  output ready);
endinterface

// Output text channel
interface sfr_out_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_present;
  logic              run_last;
  logic              stream_done;

  modport source (output valid, output out_byte, output byte_present, output run_last,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input byte_present, input run_last,
                  input stream_done, output ready);
endinterface

`default_nettype wire

// File: sv/sfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_front import sfr_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  sfr_in_if.sink                     text_in,
  output job_t                       push_job,
  output logic                       push,
  input  wire logic                  q_full
);

  localparam int CW = $clog2(MAX_LEN + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_len;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_len;

  // Pending prefix
  byte_t                 window [MAX_LEN];
  logic [CW-1:0]         count;

  logic [CW-1:0]         plen;
  logic [LEN_W-1:0]      rlen;
  logic [CW-1:0]         cnt0;
  logic [CW-1:0]         c1;
  byte_t                 win_a [MAX_LEN];
  byte_t                 win_s [MAX_LEN];
  logic [MAX_LEN:0]      ok;
  logic [CW-1:0]         ksel;
  logic                  full_match;
  logic                  accept;
  logic                  has;
  logic                  eos;
  logic                  pat_write;

  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && !q_full;
  assign has           = text_in.has_byte;
  assign eos           = text_in.end_of_stream;
  assign pat_write     = cfg_we && (cfg_index == REG_PATTERN_BYTES ||
                                    cfg_index == REG_PATTERN_LEN);

  // Effective lengths: zero acts as one, clamp to MAX_LEN
  always_comb begin
    if (pattern_len == '0) begin
      plen = CW'(1);
    end else if (pattern_len > LEN_W'(MAX_LEN)) begin
      plen = CW'(MAX_LEN);
    end else begin
      plen = pattern_len[CW-1:0];
    end
    if (replacement_len == '0) begin
      rlen = LEN_W'(1);
    end else if (replacement_len > LEN_W'(MAX_LEN)) begin
      rlen = LEN_W'(MAX_LEN);
    end else begin
      rlen = replacement_len;
    end
  end

  // Append the new byte to the pending window
  always_comb begin
    cnt0 = (count >= plen) ? '0 : count;
    c1   = has ? cnt0 + CW'(1) : cnt0;
    for (int i = 0; i < MAX_LEN; i++) begin
      win_a[i] = (has && CW'(i) == cnt0) ? text_in.data_byte : window[i];
    end
  end

  // ok[k]: window bytes from k up to c1 form a prefix of the pattern
  always_comb begin
    for (int k = 0; k <= MAX_LEN; k++) begin
      ok[k] = 1'b1;
      for (int i = 0; i < MAX_LEN; i++) begin
        if (k + i < MAX_LEN) begin
          if ((k + i) < int'(c1) &&
              win_a[k + i] != pattern_bytes[BYTE_W*i +: BYTE_W]) begin
            ok[k] = 1'b0;
          end
        end
      end
    end
  end

  // Smallest release count that leaves a valid prefix
  always_comb begin
    ksel = c1;
    for (int k = MAX_LEN; k >= 0; k--) begin
      if (ok[k]) begin
        ksel = CW'(k);
      end
    end
  end

  assign full_match = has && (c1 == plen) && ok[0];

  // Window after releasing ksel bytes
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      win_s[i] = '0;
      for (int j = 0; j < MAX_LEN; j++) begin
        if (j >= i && CW'(j - i) == ksel) begin
          win_s[i] = win_a[j];
        end
      end
    end
  end

  // Build the output run for this item
  always_comb begin
    for (int i = 0; i < MAX_LEN_CAP; i++) begin
      push_job.bytes[i] = '0;
      if (i < MAX_LEN) begin
        push_job.bytes[i] = full_match ? replacement_bytes[BYTE_W*i +: BYTE_W] : win_a[i];
      end
    end
    if (full_match) begin
      push_job.len = rlen;
    end else if (eos) begin
      push_job.len = LEN_W'(c1);
    end else begin
      push_job.len = LEN_W'(ksel);
    end
    push_job.eos = eos;
    push = accept && (push_job.len != '0 || eos);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_len       <= LEN_W'(1);
      replacement_bytes <= '0;
      replacement_len   <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES: pattern_bytes     <= cfg_wdata;
        REG_PATTERN_LEN:   pattern_len       <= cfg_wdata[LEN_W-1:0];
        REG_REPL_BYTES:    replacement_bytes <= cfg_wdata;
        REG_REPL_LEN:      replacement_len   <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // Pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (pat_write) begin
      count <= '0;
    end else if (accept) begin
      count <= (eos || full_match) ? '0 : c1 - ksel;
    end
  end

  // Pending bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= win_s;
    end
  end

`ifndef SYNTH
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && eos |=> count == '0)
    else $error("pending bytes left after end of stream");

  a_count_below_plen: assert property (@(posedge clk) disable iff (rst)
    count < plen)
    else $error("pending count reached pattern length");

  a_empty_run_is_end: assert property (@(posedge clk) disable iff (rst)
    push && push_job.len == '0 |-> push_job.eos)
    else $error("empty run queued without end of stream");
`endif

endmodule

`default_nettype wire

// File: sv/sfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small job FIFO between front and back, DEPTH >= 2
module sfr_queue import sfr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full    = (fill == FW'(DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("queue fill above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: sv/sfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_back import sfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t pop_job,
  input  wire logic empty,
  output logic      pop,
  sfr_out_if.source text_out
);

  job_t              cur;
  logic              cur_valid;
  logic [SLOT_W-1:0] idx;
  logic              last;
  logic              xfer;
  logic              take_next;

  assign last      = (cur.len == '0) || ({1'b0, idx} == cur.len - LEN_W'(1));
  assign xfer      = text_out.valid && text_out.ready;
  assign take_next = !cur_valid || (xfer && last);
  assign pop       = take_next && !empty;

  // Result fields from the current run
  assign text_out.valid        = cur_valid;
  assign text_out.byte_present = (cur.len != '0);
  assign text_out.out_byte     = (cur.len != '0) ? cur.bytes[idx] : '0;
  assign text_out.run_last     = last;
  assign text_out.stream_done  = cur.eos && last;

  // Current run and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take_next) begin
      cur_valid <= !empty;
      idx       <= '0;
    end else if (xfer) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_job;
    end
  end

`ifndef SYNTH
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    text_out.valid && !text_out.byte_present |->
      text_out.run_last && text_out.stream_done && text_out.out_byte == '0)
    else $error("empty result not marked as end");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    text_out.valid && text_out.stream_done |-> text_out.run_last)
    else $error("stream end not on last result of run");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.len != '0 |-> {1'b0, idx} < cur.len)
    else $error("byte index past run length");
`endif

endmodule

`default_nettype wire

// File: sv/stream_find_replace.sv
// Path: an item's run enters the job queue, then the back-end run register, before its
// first result can transfer. Throughput while the output is ready: one item per cycle
// while each item yields at most one result; longer runs leave one byte per cycle from
// that register, and the two-entry job queue lets the input run ahead until it fills.
// Reset (rst, synchronous): pending bytes, queue and output are emptied; the registers
// return to pattern 0 / length 1, replacement 0 / length 1.
`timescale 1ns / 1ps
`default_nettype none

module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  sfr_in_if.sink                     text_in,
  sfr_out_if.source                  text_out
);

  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // Front: match tracking and run building
  sfr_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .text_in   (text_in),
    .push_job  (push_job),
    .push      (push),
    .q_full    (q_full)
  );

  // Run queue
  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Back: byte-by-byte emission
  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .pop      (pop),
    .text_out (text_out)
  );

endmodule

`default_nettype wire
